### design/lhl_pkg.sv
// Shared types and constants for the level history LED renderer.
package lhl_pkg;

    // History storage geometry
    localparam int HIST_DEPTH = 32;
    localparam int AGE_W      = $clog2(HIST_DEPTH);
    localparam int GRID_SIZE  = 8;
    localparam int COORD_W    = $clog2(GRID_SIZE);
    localparam int BAR_TAPS   = 4;
    localparam int TAP_W      = $clog2(BAR_TAPS);
    localparam int GROUP_W    = AGE_W - TAP_W;

    // Level and arithmetic constants
    localparam int LVL_W      = 8;
    localparam int PEAK_W     = 16;
    localparam int PEAK_SHIFT = 6;
    localparam int FADE_BASE  = 32;
    localparam int FADE_SHIFT = 6;
    localparam int BAR_CLAMP  = 31;
    localparam int ROW_SHIFT  = 5;

    // Action codes; code 3 is unused and answers with value zero
    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_RIPPLE = 2'd1;
    localparam logic [1:0] ACT_BAR    = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [PEAK_W-1:0]  peak_level;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
    } t_req;

    typedef struct packed {
        logic [LVL_W-1:0] value;
        logic [1:0]       kind;
    } t_rsp;

    // Read addresses from the datapath to the history store
    typedef struct packed {
        logic [AGE_W-1:0]   age_cur;
        logic [GROUP_W-1:0] group;
    } t_hist_addr;

    // Levels read back from the history store
    typedef struct packed {
        logic [LVL_W-1:0]                cur;
        logic [LVL_W-1:0]                prev;
        logic [BAR_TAPS-1:0][LVL_W-1:0]  bar;
    } t_hist_rd;

endpackage

### design/lhl_hist.sv
// Level history store: shift line indexed by age, newest level at age zero.
module lhl_hist (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  logic [lhl_pkg::LVL_W-1:0] i_level,
    input  lhl_pkg::t_hist_addr      i_addr,
    output lhl_pkg::t_hist_rd        o_rd
);

    logic [lhl_pkg::LVL_W-1:0] r_hist [lhl_pkg::HIST_DEPTH];

    // Shift in a new level on every tick; reset clears all history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < lhl_pkg::HIST_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
        end else if (i_push) begin
            r_hist[0] <= i_level;
            for (int i = 1; i < lhl_pkg::HIST_DEPTH; i++) begin
                r_hist[i] <= r_hist[i-1];
            end
        end
    end

    // Ripple reads two neighboring ages, bar reads one aligned group
    always_comb begin
        o_rd.cur  = r_hist[i_addr.age_cur];
        o_rd.prev = r_hist[i_addr.age_cur + lhl_pkg::AGE_W'(1)];
        for (int k = 0; k < lhl_pkg::BAR_TAPS; k++) begin
            o_rd.bar[k] = r_hist[{i_addr.group, lhl_pkg::TAP_W'(k)}];
        end
    end

endmodule

### design/lhl_calc.sv
// Result datapath: tick scaling, ripple fade and bar sum for one request.
module lhl_calc (
    input  lhl_pkg::t_req             i_req,
    input  lhl_pkg::t_hist_rd         i_rd,
    output lhl_pkg::t_hist_addr       o_addr,
    output logic [lhl_pkg::LVL_W-1:0] o_level,
    output lhl_pkg::t_rsp             o_rsp
);

    localparam int PEAK_LVL_W = lhl_pkg::PEAK_W - lhl_pkg::PEAK_SHIFT;
    localparam int SQ_W       = 2 * lhl_pkg::COORD_W + 1;
    localparam int FADE_W     = $clog2(lhl_pkg::FADE_BASE + 1);
    localparam int PROD_W     = lhl_pkg::LVL_W + FADE_W;
    localparam int CLAMP_W    = $clog2(lhl_pkg::BAR_CLAMP + 1);
    localparam int SUM_W      = CLAMP_W + lhl_pkg::TAP_W;

    logic [lhl_pkg::COORD_W-1:0] dy;
    logic [PEAK_LVL_W-1:0]       peak_lvl;
    logic [SQ_W-1:0]             dist_sq;
    logic [lhl_pkg::AGE_W-1:0]   delay;
    logic [lhl_pkg::LVL_W-1:0]   rise;
    logic [FADE_W-1:0]           fade;
    logic [PROD_W-1:0]           prod;
    logic [lhl_pkg::LVL_W-1:0]   ripple_val;
    logic [lhl_pkg::LVL_W-1:0]   height;
    logic [lhl_pkg::LVL_W-1:0]   diff;
    logic [CLAMP_W-1:0]          clip [lhl_pkg::BAR_TAPS];
    logic [SUM_W-1:0]            bar_sum;

    // Tick: scale peak down and saturate at the top level
    assign peak_lvl = i_req.peak_level[lhl_pkg::PEAK_W-1:lhl_pkg::PEAK_SHIFT];
    assign o_level  = (peak_lvl > PEAK_LVL_W'((1 << lhl_pkg::LVL_W) - 1))
                    ? '1 : lhl_pkg::LVL_W'(peak_lvl);

    // Ripple delay grows with squared distance from the bottom-left corner
    assign dy      = lhl_pkg::COORD_W'(lhl_pkg::GRID_SIZE - 1) - i_req.row;
    assign dist_sq = SQ_W'(dy) * SQ_W'(dy)
                   + SQ_W'(i_req.column) * SQ_W'(i_req.column);
    assign delay   = lhl_pkg::AGE_W'(dist_sq >> 2) + lhl_pkg::AGE_W'(1);

    // History addresses: ripple reads age delay+1 and the age after it,
    // bar reads the aligned group counted back from the oldest column
    assign o_addr.age_cur = delay + lhl_pkg::AGE_W'(1);
    assign o_addr.group   = lhl_pkg::GROUP_W'(lhl_pkg::GRID_SIZE - 1) - i_req.column;

    // Ripple: rise over the previous level, faded by distance
    assign rise       = (i_rd.cur > i_rd.prev) ? (i_rd.cur - i_rd.prev) : '0;
    assign fade       = FADE_W'(lhl_pkg::FADE_BASE) - FADE_W'(delay);
    assign prod       = PROD_W'(rise) * PROD_W'(fade);
    assign ripple_val = lhl_pkg::LVL_W'(prod >> lhl_pkg::FADE_SHIFT);

    // Bar: each level above the row height, clamped, summed over the group
    assign height = {dy, lhl_pkg::ROW_SHIFT'(0)};
    always_comb begin
        diff    = '0;
        bar_sum = '0;
        for (int k = 0; k < lhl_pkg::BAR_TAPS; k++) begin
            diff    = (i_rd.bar[k] > height) ? (i_rd.bar[k] - height) : '0;
            clip[k] = (diff > lhl_pkg::LVL_W'(lhl_pkg::BAR_CLAMP))
                    ? CLAMP_W'(lhl_pkg::BAR_CLAMP) : CLAMP_W'(diff);
            bar_sum = bar_sum + SUM_W'(clip[k]);
        end
    end

    // Result select by action
    always_comb begin
        o_rsp.kind = i_req.action;
        case (i_req.action)
            lhl_pkg::ACT_TICK:   o_rsp.value = o_level;
            lhl_pkg::ACT_RIPPLE: o_rsp.value = ripple_val;
            lhl_pkg::ACT_BAR:    o_rsp.value = lhl_pkg::LVL_W'(bar_sum);
            default:             o_rsp.value = '0;
        endcase
    end

endmodule

### design/level_history_led_render.sv
// Top level of the level history LED renderer: request and result registers.
//
//  channel   | direction | handshake        | payload
//  ----------+-----------+------------------+------------------------------
//  request   | in        | i_valid/o_stall  | i_req (action, peak, col, row)
//  result    | out       | o_valid/i_stall  | o_rsp (value, kind)
//
// One request per cycle unless a stall holds the flow. A taken request loads
// the request register; its result loads the result register when the request
// advances, which a result-side stall can hold off. The history shift line is
// updated as a tick leaves the request register, so the very next request
// sees it. Reset clears all history and both registers' valid flags. A stall
// on the result side holds the result register and backs up into o_stall.
module level_history_led_render (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  lhl_pkg::t_req   i_req,
    output logic            o_valid,
    input  logic            i_stall,
    output lhl_pkg::t_rsp   o_rsp
);

    logic                      r_req_valid;
    lhl_pkg::t_req             r_req;
    logic                      r_rsp_valid;
    lhl_pkg::t_rsp             r_rsp;
    logic                      out_blocked;
    logic                      advance;
    logic                      push;
    lhl_pkg::t_hist_addr       hist_addr;
    lhl_pkg::t_hist_rd         hist_rd;
    logic [lhl_pkg::LVL_W-1:0] level;
    lhl_pkg::t_rsp             calc_rsp;

    // Flow control
    assign out_blocked = r_rsp_valid && i_stall;
    assign advance     = r_req_valid && !out_blocked;
    assign o_stall     = r_req_valid && out_blocked;
    assign push        = advance && (r_req.action == lhl_pkg::ACT_TICK);

    // Request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (!o_stall) begin
            r_req_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_req <= i_req;
        end
    end

    lhl_hist u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_level (level),
        .i_addr  (hist_addr),
        .o_rd    (hist_rd)
    );

    lhl_calc u_calc (
        .i_req   (r_req),
        .i_rd    (hist_rd),
        .o_addr  (hist_addr),
        .o_level (level),
        .o_rsp   (calc_rsp)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (!out_blocked) begin
            r_rsp_valid <= r_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_rsp <= calc_rsp;
        end
    end

    assign o_valid = r_rsp_valid;
    assign o_rsp   = r_rsp;

    // Checks
    a_advance_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_valid)
        else $error("request advanced but no result followed");

    a_ripple_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.kind == lhl_pkg::ACT_RIPPLE) |-> (o_rsp.value <= 8'd123))
        else $error("ripple value out of range");

    a_bar_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.kind == lhl_pkg::ACT_BAR) |-> (o_rsp.value <= 8'd124))
        else $error("bar value out of range");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("registers not empty after reset");

endmodule

### dv/tb_level_history_led_render.sv
// Self-checking testbench for the level history LED renderer.
module tb_level_history_led_render;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int         IDLE_LIMIT = 5000;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         REQ_W = $bits(lhl_pkg::t_req);

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          i_stall = 1'b0;
    lhl_pkg::t_req i_req   = '0;
    logic          o_stall;
    logic          o_valid;
    lhl_pkg::t_rsp o_rsp;

    level_history_led_render dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

    always #4 i_clk = ~i_clk;

    // Shadow copy of the level history
    logic [lhl_pkg::LVL_W-1:0] hist_lvl [lhl_pkg::HIST_DEPTH];
    logic [lhl_pkg::AGE_W-1:0] hist_ptr;

    lhl_pkg::t_rsp pending_rsp_q [$];
    int            err_cnt = 0;

    // Idle control for both sides
    bit tx_idle_en = 1'b0;
    bit rx_idle_en = 1'b0;
    int hold_epoch = 0;
    int hold_len   = 0;

    // Expected result for one request; updates the shadow history on a tick
    function automatic lhl_pkg::t_rsp render_predict(lhl_pkg::t_req r);
        lhl_pkg::t_rsp rsp;
        int unsigned   lvl, dy, delay, pos, prv, rise, height, sum, d, i;
        rsp.kind  = r.action;
        rsp.value = '0;
        case (r.action)
            lhl_pkg::ACT_TICK: begin
                lvl = r.peak_level >> lhl_pkg::PEAK_SHIFT;
                if (lvl > 255) lvl = 255;
                hist_ptr = hist_ptr + 1'b1;
                hist_lvl[hist_ptr] = lvl[lhl_pkg::LVL_W-1:0];
                rsp.value = lvl[lhl_pkg::LVL_W-1:0];
            end
            lhl_pkg::ACT_RIPPLE: begin
                dy    = (lhl_pkg::GRID_SIZE - 1) - r.row;
                delay = 1 + ((dy * dy + r.column * r.column) >> 2);
                pos   = (hist_ptr + lhl_pkg::HIST_DEPTH - 1 - delay) % lhl_pkg::HIST_DEPTH;
                prv   = (pos + lhl_pkg::HIST_DEPTH - 1) % lhl_pkg::HIST_DEPTH;
                rise  = (hist_lvl[lhl_pkg::AGE_W'(pos)] > hist_lvl[lhl_pkg::AGE_W'(prv)])
                      ? hist_lvl[lhl_pkg::AGE_W'(pos)] - hist_lvl[lhl_pkg::AGE_W'(prv)] : 0;
                rsp.value = lhl_pkg::LVL_W'((rise * (lhl_pkg::FADE_BASE - delay))
                                            >> lhl_pkg::FADE_SHIFT);
            end
            lhl_pkg::ACT_BAR: begin
                height = ((lhl_pkg::GRID_SIZE - 1) - r.row) * 32;
                sum    = 0;
                for (i = 1; i <= lhl_pkg::BAR_TAPS; i++) begin
                    lvl = hist_lvl[lhl_pkg::AGE_W'(hist_ptr + r.column * 4 + i)];
                    d   = (lvl > height) ? lvl - height : 0;
                    sum += (d > lhl_pkg::BAR_CLAMP) ? lhl_pkg::BAR_CLAMP : d;
                end
                rsp.value = sum[lhl_pkg::LVL_W-1:0];
            end
            default: rsp.value = '0;
        endcase
        return rsp;
    endfunction

    // Offer one request and wait until it is taken
    task automatic send_req(lhl_pkg::t_req r);
        int gap;
        if (tx_idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 9);
            i_valid <= 1'b0;
            i_req   <= lhl_pkg::t_req'(REQ_W'($urandom));
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (o_stall);
        pending_rsp_q.push_back(render_predict(r));
    endtask

    function automatic lhl_pkg::t_req make_req(logic [1:0] act, int unsigned peak,
                                               int unsigned col, int unsigned rw);
        lhl_pkg::t_req r;
        r.action     = act;
        r.peak_level = peak[lhl_pkg::PEAK_W-1:0];
        r.column     = col[lhl_pkg::COORD_W-1:0];
        r.row        = rw[lhl_pkg::COORD_W-1:0];
        return r;
    endfunction

    // Random request, weighted toward ticks and queries with spread levels
    function automatic lhl_pkg::t_req rand_req();
        lhl_pkg::t_req r;
        int unsigned   sel;
        r   = lhl_pkg::t_req'(REQ_W'($urandom));
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            r.action = lhl_pkg::ACT_TICK;
            case ($urandom_range(0, 3))
                0:       r.peak_level = lhl_pkg::PEAK_W'($urandom_range(0, 65535));
                1:       r.peak_level = lhl_pkg::PEAK_W'($urandom_range(0, 16383));
                2:       r.peak_level = lhl_pkg::PEAK_W'($urandom_range(0, 4095));
                default: r.peak_level = lhl_pkg::PEAK_W'($urandom_range(12000, 16400));
            endcase
        end else if (sel < 68) begin
            r.action = lhl_pkg::ACT_RIPPLE;
        end else if (sel < 96) begin
            r.action = lhl_pkg::ACT_BAR;
        end else begin
            r.action = ACT_UNUSED;
        end
        return r;
    endfunction

    // Result checker
    always @(posedge i_clk) begin
        lhl_pkg::t_rsp exp_rsp;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_rsp_q.size() == 0) begin
                $display("%0t: unexpected result value=%0d kind=%0d",
                         $time, o_rsp.value, o_rsp.kind);
                err_cnt++;
            end else begin
                exp_rsp = pending_rsp_q.pop_front();
                if (o_rsp.value !== exp_rsp.value) begin
                    $display("%0t: value mismatch expected=%0d actual=%0d",
                             $time, exp_rsp.value, o_rsp.value);
                    err_cnt++;
                end
                if (o_rsp.kind !== exp_rsp.kind) begin
                    $display("%0t: kind mismatch expected=%0d actual=%0d",
                             $time, exp_rsp.kind, o_rsp.kind);
                    err_cnt++;
                end
            end
        end
    end

    // Receiver stall: long hold-off on request, otherwise random bursts
    int hold_left  = 0;
    int burst_left = 0;
    int hold_done  = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_done != hold_epoch) begin
            hold_done = hold_epoch;
            hold_left = hold_len - 1;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (burst_left > 0) begin
            burst_left--;
            i_stall <= 1'b1;
        end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
            burst_left = $urandom_range(0, 8);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Watchdog on cycles with no handshake on either side
    int idle_cnt = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    // Queries against the cleared history
    task automatic test_cleared_history();
        send_req(make_req(lhl_pkg::ACT_RIPPLE, 0, 0, 7));
        send_req(make_req(lhl_pkg::ACT_BAR, 16'hFFFF, 7, 7));
        send_req(make_req(lhl_pkg::ACT_BAR, 0, 0, 0));
    endtask

    // Field extremes, clamps, falling levels and the unused action
    task automatic test_directed_edges();
        send_req(make_req(lhl_pkg::ACT_TICK, 0, 7, 0));
        send_req(make_req(lhl_pkg::ACT_TICK, 63, 0, 7));
        send_req(make_req(lhl_pkg::ACT_TICK, 64, 0, 0));
        send_req(make_req(lhl_pkg::ACT_TICK, 16319, 0, 0));
        send_req(make_req(lhl_pkg::ACT_TICK, 16320, 0, 0));
        send_req(make_req(lhl_pkg::ACT_TICK, 65535, 7, 7));
        send_req(make_req(lhl_pkg::ACT_TICK, 0, 0, 0));       // falling step
        send_req(make_req(lhl_pkg::ACT_TICK, 16'h5555, 0, 0));
        send_req(make_req(lhl_pkg::ACT_TICK, 16'hAAAA, 0, 0));
        // nearest cell looks at the shallowest ages, farthest cell goes deep
        send_req(make_req(lhl_pkg::ACT_RIPPLE, 0, 0, 7));
        send_req(make_req(lhl_pkg::ACT_TICK, 3000, 0, 0));
        send_req(make_req(lhl_pkg::ACT_RIPPLE, 0, 0, 7));
        send_req(make_req(lhl_pkg::ACT_RIPPLE, 0, 7, 0));
        send_req(make_req(lhl_pkg::ACT_RIPPLE, 0, 3, 4));
        send_req(make_req(lhl_pkg::ACT_BAR, 0, 0, 7));
        send_req(make_req(lhl_pkg::ACT_BAR, 0, 7, 0));
        send_req(make_req(lhl_pkg::ACT_BAR, 0, 5, 2));
        send_req(make_req(ACT_UNUSED, 16'hFFFF, 7, 7));
        send_req(make_req(ACT_UNUSED, 0, 0, 0));
    endtask

    task automatic test_random_mix(int n);
        for (int k = 0; k < n; k++) send_req(rand_req());
    endtask

    // Hold the result side off while requests keep coming
    task automatic test_backpressure();
        tx_idle_en = 1'b0;
        hold_len   = 150;
        hold_epoch++;
        for (int k = 0; k < 30; k++) send_req(rand_req());
    endtask

    initial begin
        for (int k = 0; k < lhl_pkg::HIST_DEPTH; k++) hist_lvl[k] = '0;
        hist_ptr = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_cleared_history();
        test_directed_edges();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        test_random_mix(900);
        test_backpressure();
        tx_idle_en = 1'b1;
        test_random_mix(100);
        // last stretch at full rate
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        test_random_mix(250);

        i_valid <= 1'b0;
        while (pending_rsp_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0 && pending_rsp_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### files.f
design/lhl_pkg.sv
design/lhl_hist.sv
design/lhl_calc.sv
design/level_history_led_render.sv
dv/tb_level_history_led_render.sv
